// ===== rtl/smm_pkg.sv =====
// ----------------------------------------------------------------------------
// smm_pkg - shared types and constants for the square matrix multiplier
// Element store geometry, request codes and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package smm_pkg;

  localparam int MAX_DIM    = 8;
  localparam int DATA_WIDTH = 32;

  // Fixed port widths
  localparam int REQ_W   = 2;
  localparam int POS_W   = 3;
  localparam int VALUE_W = 32;
  localparam int SIZE_W  = 4;

  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

  localparam logic [SIZE_W-1:0] RESET_SIZE = SIZE_W'(4);

  localparam logic [REQ_W-1:0] REQ_LOAD_INPUT  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_WEIGHT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COMPUTE     = 2'd2;

  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [POS_W-1:0]      pos_t;

  // Controller -> datapath
  typedef struct packed {
    logic  wr_input;
    logic  wr_weight;
    addr_t wr_addr;
    logic  rd_en;
    addr_t rd_in_addr;
    addr_t rd_wt_addr;
    logic  first;     // first term of a dot product
    logic  fin;       // final term of a dot product
    logic  last;      // final element of the product matrix
    pos_t  row;
    pos_t  col;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic pipe_busy;  // terms still in the read/multiply stages
    logic out_free;   // output register empty or draining this cycle
    logic res_load;   // a finished sum is written to the output register
  } dp_sts_t;

  // Row-major store address of element (row, col)
  function automatic addr_t elem_addr(input pos_t row, input pos_t col);
    return ADDR_W'(int'(row) * MAX_DIM + int'(col));
  endfunction

endpackage

// ===== rtl/smm_datapath.sv =====
// ----------------------------------------------------------------------------
// smm_datapath - element stores, multiplier and accumulator
// Two element memories with registered reads, a product register, the
// running sum and the result output register.
// ----------------------------------------------------------------------------
module smm_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  smm_pkg::dp_cmd_t               cmd,
  output smm_pkg::dp_sts_t               sts,
  input  logic signed [smm_pkg::VALUE_W-1:0] elem_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [smm_pkg::POS_W-1:0]      out_row,
  output logic [smm_pkg::POS_W-1:0]      out_col,
  output logic signed [smm_pkg::VALUE_W-1:0] out_value,
  output logic                           out_last
);
  import smm_pkg::*;

  data_t input_mem  [MAX_DIM*MAX_DIM];
  data_t weight_mem [MAX_DIM*MAX_DIM];

  // Read stage
  logic  s1_valid;
  data_t s1_a;
  data_t s1_b;
  logic  s1_first, s1_fin, s1_last;
  pos_t  s1_row, s1_col;

  // Product stage
  logic  s2_valid;
  data_t s2_prod;
  logic  s2_first, s2_fin, s2_last;
  pos_t  s2_row, s2_col;

  data_t acc;
  data_t sum;
  logic [2*DATA_WIDTH-1:0] full_prod;

  always_ff @(posedge clk) begin
    if (cmd.wr_input) begin
      input_mem[cmd.wr_addr] <= elem_value[DATA_WIDTH-1:0];
    end
    if (cmd.wr_weight) begin
      weight_mem[cmd.wr_addr] <= elem_value[DATA_WIDTH-1:0];
    end
    if (cmd.rd_en) begin
      s1_a <= input_mem[cmd.rd_in_addr];
      s1_b <= weight_mem[cmd.rd_wt_addr];
    end
  end

  assign full_prod = s1_a * s1_b;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      s1_first <= cmd.first;
      s1_fin   <= cmd.fin;
      s1_last  <= cmd.last;
      s1_row   <= cmd.row;
      s1_col   <= cmd.col;
    end
    if (s1_valid) begin
      s2_prod  <= full_prod[DATA_WIDTH-1:0];
      s2_first <= s1_first;
      s2_fin   <= s1_fin;
      s2_last  <= s1_last;
      s2_row   <= s1_row;
      s2_col   <= s1_col;
    end
    if (s2_valid) begin
      acc <= sum;
    end
  end

  assign sum = s2_first ? s2_prod : acc + s2_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.rd_en;
      s2_valid <= s1_valid;
    end
  end

  // Output register; the controller only issues a new element once it is free
  assign sts.res_load  = s2_valid && s2_fin;
  assign sts.pipe_busy = s1_valid || s2_valid;
  assign sts.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sts.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sts.res_load) begin
      out_row   <= s2_row;
      out_col   <= s2_col;
      out_value <= VALUE_W'(signed'(sum));
      out_last  <= s2_last;
    end
  end

endmodule

// ===== rtl/smm_ctrl.sv =====
// ----------------------------------------------------------------------------
// smm_ctrl - request decode and product sequencer
// Holds the size register, decodes loads into store writes and walks the
// row, column and term counters of a compute request.
// ----------------------------------------------------------------------------
module smm_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [smm_pkg::SIZE_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [smm_pkg::REQ_W-1:0]     req_type,
  input  logic [smm_pkg::POS_W-1:0]     elem_row,
  input  logic [smm_pkg::POS_W-1:0]     elem_col,
  output smm_pkg::dp_cmd_t              cmd,
  input  smm_pkg::dp_sts_t              sts
);
  import smm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WAIT  = 3'b010,
    ST_ISSUE = 3'b100
  } state_t;

  state_t state, state_next;
  logic [SIZE_W-1:0] matrix_size;
  logic [IDX_W-1:0]  r, c, i;
  logic [IDX_W-1:0]  r_next, c_next, i_next;
  logic              all_issued, all_issued_next;
  logic [IDX_W-1:0]  n_last;
  logic              in_xfer;
  logic              pos_ok;
  logic              fin;
  logic              last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= RESET_SIZE;
    end else if (cfg_valid && cfg_ready) begin
      matrix_size <= cfg_data;
    end
  end

  // Size 0 runs as 1, anything above the store size saturates
  always_comb begin
    if (matrix_size == '0) begin
      n_last = '0;
    end else if (int'(matrix_size) > MAX_DIM) begin
      n_last = IDX_W'(MAX_DIM - 1);
    end else begin
      n_last = IDX_W'(matrix_size - SIZE_W'(1));
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign pos_ok   = (int'(elem_row) < MAX_DIM) && (int'(elem_col) < MAX_DIM);
  assign fin      = (i == n_last);
  assign last     = fin && (r == n_last) && (c == n_last);

  always_comb begin
    cmd            = '0;
    cmd.wr_addr    = elem_addr(elem_row, elem_col);
    cmd.rd_in_addr = elem_addr(POS_W'(r), POS_W'(i));
    cmd.rd_wt_addr = elem_addr(POS_W'(i), POS_W'(c));
    cmd.first      = (i == '0);
    cmd.fin        = fin;
    cmd.last       = last;
    cmd.row        = POS_W'(r);
    cmd.col        = POS_W'(c);
    cmd.rd_en      = (state == ST_ISSUE);
    if (in_xfer && pos_ok) begin
      unique case (req_type)
        REQ_LOAD_INPUT:  cmd.wr_input  = 1'b1;
        REQ_LOAD_WEIGHT: cmd.wr_weight = 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next      = state;
    r_next          = r;
    c_next          = c;
    i_next          = i;
    all_issued_next = all_issued;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer && req_type == REQ_COMPUTE) begin
          r_next          = '0;
          c_next          = '0;
          i_next          = '0;
          all_issued_next = 1'b0;
          state_next      = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (all_issued) begin
          if (!sts.pipe_busy) begin
            state_next = ST_IDLE;
          end
        end else if (!sts.pipe_busy && sts.out_free) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (fin) begin
          i_next     = '0;
          state_next = ST_WAIT;
          if (last) begin
            all_issued_next = 1'b1;
          end else if (c == n_last) begin
            c_next = '0;
            r_next = r + IDX_W'(1);
          end else begin
            c_next = c + IDX_W'(1);
          end
        end else begin
          i_next = i + IDX_W'(1);
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      r          <= '0;
      c          <= '0;
      i          <= '0;
      all_issued <= 1'b0;
    end else begin
      state      <= state_next;
      r          <= r_next;
      c          <= c_next;
      i          <= i_next;
      all_issued <= all_issued_next;
    end
  end

endmodule

// ===== rtl/square_matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// square_matrix_multiply - n-by-n signed integer matrix product
// Loadable input and weight stores feeding one multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel (cfg_valid/cfg_ready, always ready) sets matrix_size n;
//   write it only while the block is idle. 0 runs as 1, >8 runs as 8.
//   in channel (in_valid/in_stall): req_type 0/1 loads elem_value into the
//   input/weight store at (elem_row, elem_col), no result.
//   req_type 2 starts a compute; req_type 3 is dropped.
//   A compute produces n*n out transfers in row-major order, out_last set
//   on the final one. in_stall stays high from the compute transfer until
//   the last result sits in the output register.
// Flow: each result takes n store reads through the single multiply-accumulate
//   unit plus read, product and sum stages. The next element is issued only
//   once the previous one has left the read and product stages and the output
//   register is free, so an out_stall holds off the sequencer with the waiting
//   result held steady. Loads are accepted while the block is idle.
// Reset: size returns to 4, output and pipeline valids clear. Store
//   contents are undefined until loaded.
// ----------------------------------------------------------------------------
module square_matrix_multiply (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [smm_pkg::SIZE_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [smm_pkg::REQ_W-1:0]          req_type,
  input  logic [smm_pkg::POS_W-1:0]          elem_row,
  input  logic [smm_pkg::POS_W-1:0]          elem_col,
  input  logic signed [smm_pkg::VALUE_W-1:0] elem_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [smm_pkg::POS_W-1:0]          out_row,
  output logic [smm_pkg::POS_W-1:0]          out_col,
  output logic signed [smm_pkg::VALUE_W-1:0] out_value,
  output logic                               out_last
);
  import smm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer: size register, load decode, row/col/term counters
  smm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .elem_row  (elem_row),
    .elem_col  (elem_col),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Stores, multiplier, accumulator and output register
  smm_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .elem_value (elem_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_value  (out_value),
    .out_last   (out_last)
  );

`ifndef ASSERT_OFF
  // A finished sum never overwrites a result that is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(sts.res_load && out_valid && out_stall))
    else $error("result register overwritten while stalled");

  // The input side is open only with the multiply pipeline drained
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !sts.pipe_busy)
    else $error("input accepted with terms in flight");

  // Nothing follows the final product element
  a_last_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> !sts.pipe_busy && !cmd.rd_en)
    else $error("terms issued after the final element");

  // Store writes only happen on an input transfer
  a_write_on_xfer: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_input || cmd.wr_weight |-> in_valid && !in_stall)
    else $error("store written without an input transfer");
`endif

endmodule
